FILE: sv/lnsc_pkg.sv
package lnsc_pkg;

  localparam int CYC_W   = 32;
  localparam int CNT_W   = $clog2(CYC_W) + 1;
  localparam int MOD_W   = 5;
  localparam int LFSR_W  = 16;
  localparam int VOL_W   = 4;
  localparam int LEN_W   = 7;
  localparam int CFG_IW  = 3;
  localparam int CFG_DW  = 8;

  localparam logic [LFSR_W-1:0] LFSR_SEED  = 16'hFFFF;
  localparam logic [LEN_W-1:0]  LEN_FULL   = 7'd64;
  localparam int                LEN_TICK_B = 14;
  localparam int                ENV_TICK_B = 16;
  localparam logic [MOD_W-1:0]  MOD_BASE   = 5'd4;
  localparam logic [VOL_W-1:0]  VOL_MAX    = 4'd15;

  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_TRIGGER = 1'b1;

  localparam logic [CFG_IW-1:0] REG_CLOCK_SHIFT    = 3'd0;
  localparam logic [CFG_IW-1:0] REG_CLOCK_DIVIDER  = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SHORT_MODE     = 3'd2;
  localparam logic [CFG_IW-1:0] REG_INITIAL_VOLUME = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ENVELOPE_UP    = 3'd4;
  localparam logic [CFG_IW-1:0] REG_ENVELOPE_PACE  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_LENGTH_LOAD    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_LENGTH_ENABLE  = 3'd7;

  typedef struct packed {
    logic [3:0] clock_shift;
    logic [2:0] clock_divider;
    logic       short_mode;
    logic [3:0] initial_volume;
    logic       envelope_up;
    logic [2:0] envelope_pace;
    logic [5:0] length_load;
    logic       length_enable;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic done;
  } sts_t;

endpackage

FILE: sv/lnsc_if.sv
interface lnsc_in_if;
  import lnsc_pkg::*;
  logic             valid;
  logic             ready;
  logic             func;
  logic [CYC_W-1:0] cycle_index;
  modport source (output valid, func, cycle_index, input ready);
  modport sink (input valid, func, cycle_index, output ready);
endinterface

interface lnsc_out_if;
  import lnsc_pkg::*;
  logic             valid;
  logic             ready;
  logic [VOL_W-1:0] sample;
  logic             channel_on;
  modport source (output valid, sample, channel_on, input ready);
  modport sink (input valid, sample, channel_on, output ready);
endinterface

interface lnsc_cfg_if;
  import lnsc_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_IW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: sv/lnsc_cfg.sv
module lnsc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       wr_en,
  input  logic [lnsc_pkg::CFG_IW-1:0] wr_index,
  input  logic [lnsc_pkg::CFG_DW-1:0] wr_data,
  output lnsc_pkg::cfg_t             cfg
);
  import lnsc_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_CLOCK_SHIFT:    cfg_nxt.clock_shift    = wr_data[3:0];
        REG_CLOCK_DIVIDER:  cfg_nxt.clock_divider  = wr_data[2:0];
        REG_SHORT_MODE:     cfg_nxt.short_mode     = wr_data[0];
        REG_INITIAL_VOLUME: cfg_nxt.initial_volume = wr_data[3:0];
        REG_ENVELOPE_UP:    cfg_nxt.envelope_up    = wr_data[0];
        REG_ENVELOPE_PACE:  cfg_nxt.envelope_pace  = wr_data[2:0];
        REG_LENGTH_LOAD:    cfg_nxt.length_load    = wr_data[5:0];
        REG_LENGTH_ENABLE:  cfg_nxt.length_enable  = wr_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/lnsc_ctrl.sv
module lnsc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  lnsc_pkg::sts_t sts,
  output lnsc_pkg::cmd_t cmd
);
  import lnsc_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts.done) begin
          cmd.step = 1'b1;
        end else if (slot_free) begin
          cmd.commit    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/lnsc_dp.sv
module lnsc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lnsc_pkg::cfg_t             cfg,
  input  lnsc_pkg::cmd_t             cmd,
  output lnsc_pkg::sts_t             sts,
  input  logic                       in_func,
  input  logic [lnsc_pkg::CYC_W-1:0] in_cycle_index,
  output logic [lnsc_pkg::VOL_W-1:0] out_sample,
  output logic                       out_channel_on
);
  import lnsc_pkg::*;

  // bit-serial remainder
  logic [CYC_W-1:0] cyc_r, cyc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [MOD_W-1:0] rem_r, rem_nxt;
  logic             trig_r, trig_nxt;
  logic             len_hit_r, len_hit_nxt;
  logic             env_hit_r, env_hit_nxt;
  logic [MOD_W-1:0] modulus;
  logic [MOD_W:0]   rem_sh;

  // channel state
  logic [LFSR_W-1:0] lfsr_r, lfsr_nxt;
  logic [2:0]        div_cnt_r, div_cnt_nxt;
  logic [LEN_W-1:0]  len_cnt_r, len_cnt_nxt;
  logic              len_run_r, len_run_nxt;
  logic              env_run_r, env_run_nxt;
  logic [2:0]        env_cnt_r, env_cnt_nxt;
  logic [VOL_W-1:0]  vol_r, vol_nxt;
  logic              muted_r, muted_nxt;
  logic              status_r, status_nxt;
  logic              dac_r, dac_nxt;
  logic [VOL_W-1:0]  sample_r, sample_nxt;
  logic              chan_on_r, chan_on_nxt;

  logic [3:0]       div_inc, div_lim;
  logic [3:0]       env_inc;
  logic [LEN_W-1:0] len_start;
  logic             fb;

  assign modulus = MOD_BASE + {1'b0, cfg.clock_shift}
                   - {{(MOD_W-1){1'b0}}, (cfg.clock_divider == 3'd0)};
  assign rem_sh  = {rem_r, cyc_r[CYC_W-1]};
  assign sts.done = trig_r || cnt_r[CNT_W-1];

  always_comb begin
    cyc_nxt     = cyc_r;
    cnt_nxt     = cnt_r;
    rem_nxt     = rem_r;
    trig_nxt    = trig_r;
    len_hit_nxt = len_hit_r;
    env_hit_nxt = env_hit_r;
    if (cmd.load) begin
      cyc_nxt     = in_cycle_index;
      cnt_nxt     = '0;
      rem_nxt     = '0;
      trig_nxt    = (in_func == FUNC_TRIGGER);
      len_hit_nxt = (in_cycle_index[LEN_TICK_B-1:0] == '0);
      env_hit_nxt = (in_cycle_index[ENV_TICK_B-1:0] == '0);
    end else if (cmd.step) begin
      cyc_nxt = {cyc_r[CYC_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (rem_sh >= {1'b0, modulus}) begin
        rem_nxt = MOD_W'(rem_sh - {1'b0, modulus});
      end else begin
        rem_nxt = rem_sh[MOD_W-1:0];
      end
    end
  end

  always_comb begin
    lfsr_nxt    = lfsr_r;
    div_cnt_nxt = div_cnt_r;
    len_cnt_nxt = len_cnt_r;
    len_run_nxt = len_run_r;
    env_run_nxt = env_run_r;
    env_cnt_nxt = env_cnt_r;
    vol_nxt     = vol_r;
    muted_nxt   = muted_r;
    status_nxt  = status_r;
    dac_nxt     = dac_r;
    sample_nxt  = sample_r;
    chan_on_nxt = chan_on_r;
    div_inc     = {1'b0, div_cnt_r} + 4'd1;
    div_lim     = (cfg.clock_divider == 3'd0) ? 4'd1 : {1'b0, cfg.clock_divider};
    len_start   = (cfg.length_load == 6'd0) ? LEN_FULL : {1'b0, cfg.length_load};
    env_inc     = '0;
    fb          = lfsr_r[0] ^ lfsr_r[1];
    if (cmd.commit) begin
      if (trig_r) begin
        muted_nxt   = 1'b0;
        status_nxt  = 1'b1;
        vol_nxt     = cfg.initial_volume;
        lfsr_nxt    = LFSR_SEED;
        env_run_nxt = 1'b0;
        len_run_nxt = 1'b0;
        if (!dac_r) begin
          muted_nxt  = 1'b1;
          status_nxt = 1'b0;
        end
      end else begin
        dac_nxt = (cfg.initial_volume != 4'd0) || cfg.envelope_up;
        if (!dac_nxt) begin
          status_nxt = 1'b0;
          muted_nxt  = 1'b0;
        end
        // noise register
        if (rem_r == '0) begin
          if (div_inc >= div_lim) begin
            div_cnt_nxt = 3'd0;
            lfsr_nxt    = {1'b0, fb, lfsr_r[14:8],
                           (cfg.short_mode ? fb : lfsr_r[7]), lfsr_r[6:1]};
          end else begin
            div_cnt_nxt = div_inc[2:0];
          end
        end
        // length counter
        if (!len_run_nxt && cfg.length_enable) begin
          len_cnt_nxt = len_start;
          len_run_nxt = 1'b1;
        end
        if (!cfg.length_enable) begin
          len_run_nxt = 1'b0;
        end
        if (len_hit_r && cfg.length_enable) begin
          if (len_cnt_nxt == LEN_FULL) begin
            len_cnt_nxt = len_start;
            muted_nxt   = 1'b1;
            status_nxt  = 1'b0;
          end else begin
            len_cnt_nxt = len_cnt_nxt + 1'b1;
          end
        end
        // envelope
        if (cfg.envelope_pace == 3'd0) begin
          env_run_nxt = 1'b0;
        end
        if (cfg.envelope_pace != 3'd0 && !env_run_nxt) begin
          env_run_nxt = 1'b1;
          env_cnt_nxt = 3'd0;
          vol_nxt     = cfg.initial_volume;
        end
        if (!dac_nxt) begin
          muted_nxt  = 1'b1;
          status_nxt = 1'b0;
        end
        if (env_run_nxt && env_hit_r) begin
          env_inc = {1'b0, env_cnt_nxt} + 4'd1;
          if (env_inc >= {1'b0, cfg.envelope_pace}) begin
            env_cnt_nxt = 3'd0;
            if (cfg.envelope_up) begin
              if (vol_nxt < VOL_MAX) begin
                vol_nxt = vol_nxt + 1'b1;
              end
            end else if (vol_nxt != '0) begin
              vol_nxt = vol_nxt - 1'b1;
            end
          end else begin
            env_cnt_nxt = env_inc[2:0];
          end
        end
      end
      sample_nxt  = (!muted_nxt && lfsr_nxt[0]) ? vol_nxt : '0;
      chan_on_nxt = status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r    <= LFSR_SEED;
      div_cnt_r <= '0;
      len_cnt_r <= '0;
      len_run_r <= 1'b0;
      env_run_r <= 1'b0;
      env_cnt_r <= '0;
      vol_r     <= '0;
      muted_r   <= 1'b0;
      status_r  <= 1'b0;
      dac_r     <= 1'b0;
      cnt_r     <= '0;
      trig_r    <= 1'b0;
    end else begin
      lfsr_r    <= lfsr_nxt;
      div_cnt_r <= div_cnt_nxt;
      len_cnt_r <= len_cnt_nxt;
      len_run_r <= len_run_nxt;
      env_run_r <= env_run_nxt;
      env_cnt_r <= env_cnt_nxt;
      vol_r     <= vol_nxt;
      muted_r   <= muted_nxt;
      status_r  <= status_nxt;
      dac_r     <= dac_nxt;
      cnt_r     <= cnt_nxt;
      trig_r    <= trig_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cyc_r     <= cyc_nxt;
    rem_r     <= rem_nxt;
    len_hit_r <= len_hit_nxt;
    env_hit_r <= env_hit_nxt;
    sample_r  <= sample_nxt;
    chan_on_r <= chan_on_nxt;
  end

  assign out_sample     = sample_r;
  assign out_channel_on = chan_on_r;

endmodule

FILE: sv/lfsr_noise_sound_channel_core.sv
// channel | dir | payload
// in_ch   | in  | func, cycle_index
// out_ch  | out | sample, channel_on
// cfg_ch  | in  | index, data
//
// a tick beat runs from accept to ready again through the 32-step
// bit-serial remainder of cycle_index by the lfsr modulus, then a commit step
// a trigger beat goes from accept straight to its commit step
// synchronous active-low reset; noise register resets to all ones
// the result sits in an output register, so a new beat is taken while it waits;
// the commit of the next beat holds until that result is taken
module lfsr_noise_sound_channel_core (
  input  logic       clk,
  input  logic       rst_n,
  lnsc_in_if.sink    in_ch,
  lnsc_out_if.source out_ch,
  lnsc_cfg_if.sink   cfg_ch
);
  import lnsc_pkg::*;

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  assign cfg_ch.ready = 1'b1;

  lnsc_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  lnsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lnsc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .cmd            (cmd),
    .sts            (sts),
    .in_func        (in_ch.func),
    .in_cycle_index (in_ch.cycle_index),
    .out_sample     (out_ch.sample),
    .out_channel_on (out_ch.channel_on)
  );

endmodule
